/* sv/cbf_pkg.sv */
package cbf_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam logic [6:0] CapacityReset = 7'd64;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef struct packed {
    action_e           action;
    logic signed [7:0] data_in;
    logic [6:0]        position;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic signed [7:0] read_data;
    logic [6:0]        item_count;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_MOD  = 5'b00100,
    ST_READ = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic mod_step;
    logic read;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic peek_hit;
    logic mod_last;
  } dp_status_t;

endpackage

/* sv/cbf_ctrl.sv */
module cbf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  cbf_pkg::dp_status_t status_i,
  output cbf_pkg::ctrl_cmd_t  cmd_o
);

  cbf_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cbf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = cbf_pkg::ST_EXEC;
        end
      end
      cbf_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = status_i.peek_hit ? cbf_pkg::ST_MOD : cbf_pkg::ST_DONE;
      end
      cbf_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          state_d = cbf_pkg::ST_READ;
        end
      end
      cbf_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = cbf_pkg::ST_DONE;
      end
      cbf_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = cbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cbf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/cbf_datapath.sv */
module cbf_datapath #(
  parameter int unsigned DEPTH = cbf_pkg::DepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  cbf_pkg::in_item_t   in_item_i,
  output cbf_pkg::out_item_t  out_item_o,
  input  cbf_pkg::ctrl_cmd_t  cmd_i,
  output cbf_pkg::dp_status_t status_o
);

  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CAPW = $clog2(DEPTH + 1);
  localparam int unsigned SW   = $clog2(DEPTH + 128);
  localparam int unsigned BW   = $clog2(SW);

  logic signed [7:0] mem [DEPTH];

  cbf_pkg::in_item_t  item_q;
  cbf_pkg::out_item_t out_item_q;

  logic [6:0]      capacity_q, capacity_d;
  logic [IW-1:0]   newest_q, newest_d;
  logic [IW-1:0]   oldest_q, oldest_d;
  logic [6:0]      held_q, held_d;
  logic [CAPW-1:0] cap_use;

  logic              res_status_q, res_status_d;
  logic [6:0]        res_count_q;
  logic signed [7:0] res_rd_q;

  logic [SW-1:0]   sum_q;
  logic [CAPW-1:0] rem_q;
  logic [BW-1:0]   bit_q;
  logic [CAPW:0]   shifted;

  logic full, hit, mem_we;
  logic [IW-1:0] newest_next;

  function automatic logic [IW-1:0] advance(logic [IW-1:0] idx, logic [CAPW-1:0] cap);
    logic [31:0] nxt;
    nxt = 32'(idx) + 32'd1;
    if (nxt >= 32'(cap)) begin
      return '0;
    end
    return IW'(nxt);
  endfunction

  always_comb begin
    if (capacity_q == 7'd0) begin
      cap_use = CAPW'(1);
    end else if (32'(capacity_q) > DEPTH) begin
      cap_use = CAPW'(DEPTH);
    end else begin
      cap_use = CAPW'(capacity_q);
    end
  end

  assign full = 32'(held_q) >= 32'(cap_use);
  assign hit = (item_q.action == cbf_pkg::ACT_PEEK) && (held_q != 7'd0) &&
               (item_q.position != 7'd0) && (item_q.position <= held_q);
  assign newest_next = (held_q != 7'd0) ? advance(newest_q, cap_use) : newest_q;

  always_comb begin
    capacity_d = cfg_we_i ? cfg_wdata_i : capacity_q;
    newest_d = newest_q;
    oldest_d = oldest_q;
    held_d = held_q;
    res_status_d = 1'b0;
    mem_we = 1'b0;
    case (item_q.action)
      cbf_pkg::ACT_ADD: begin
        if (full) begin
          res_status_d = 1'b1;
        end else begin
          mem_we = cmd_i.exec;
          newest_d = newest_next;
          held_d = held_q + 7'd1;
        end
      end
      cbf_pkg::ACT_REMOVE: begin
        if (held_q == 7'd0) begin
          res_status_d = 1'b1;
        end else begin
          if (held_q != 7'd1) begin
            oldest_d = advance(oldest_q, cap_use);
          end
          held_d = held_q - 7'd1;
        end
      end
      cbf_pkg::ACT_PEEK: begin
        res_status_d = 1'b0;
      end
      default: begin
        res_status_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= cbf_pkg::CapacityReset;
      newest_q <= '0;
      oldest_q <= '0;
      held_q <= '0;
    end else begin
      capacity_q <= capacity_d;
      if (cmd_i.exec) begin
        newest_q <= newest_d;
        oldest_q <= oldest_d;
        held_q <= held_d;
      end
    end
  end

  assign shifted = {rem_q, sum_q[bit_q]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.exec) begin
      res_status_q <= res_status_d;
      res_count_q <= held_d;
      sum_q <= SW'(32'(oldest_q) + 32'(item_q.position) - 32'd1);
      rem_q <= '0;
      bit_q <= BW'(SW - 1);
    end
    if (cmd_i.mod_step) begin
      if (shifted >= {1'b0, cap_use}) begin
        rem_q <= CAPW'(shifted - {1'b0, cap_use});
      end else begin
        rem_q <= CAPW'(shifted);
      end
      bit_q <= bit_q - BW'(1);
    end
    if (cmd_i.load_out) begin
      out_item_q.status <= res_status_q;
      out_item_q.read_data <= res_rd_q;
      out_item_q.item_count <= res_count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[newest_next] <= item_q.data_in;
    end
    if (cmd_i.exec) begin
      res_rd_q <= '0;
    end else if (cmd_i.read) begin
      res_rd_q <= mem[rem_q[IW-1:0]];
    end
  end

  assign status_o.peek_hit = hit;
  assign status_o.mod_last = (bit_q == '0);
  assign out_item_o = out_item_q;

endmodule

/* sv/circular_byte_fifo_with_peek.sv */
// flow: an accepted item goes through EXEC and then DONE, where the result is loaded;
//   a peek in range adds SW bit-serial modulo steps in MOD and a read in READ, with
//   SW = clog2(DEPTH + 128) (8 at DEPTH 64); one item at a time, taken only in IDLE
// reset: indices and count cleared, capacity 64, entry store not cleared
module circular_byte_fifo_with_peek #(
  parameter int unsigned DEPTH = cbf_pkg::DepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cbf_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cbf_pkg::out_item_t out_item_o
);

  cbf_pkg::ctrl_cmd_t  cmd;
  cbf_pkg::dp_status_t status;

  cbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbf_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* sv/cbf_checker.sv */
module cbf_checker #(
  parameter int unsigned DEPTH = cbf_pkg::DepthDefault
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input cbf_pkg::out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_item_o.item_count) <= DEPTH)
    else $error("item count above depth");

  // nonzero read data only on a successful operation
  a_rd_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.read_data != 8'sd0) |-> !out_item_o.status)
    else $error("read data on failed operation");

endmodule

bind circular_byte_fifo_with_peek cbf_checker #(
  .DEPTH(DEPTH)
) u_cbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
